### design/rv32ex_pkg.sv
// Shared types and constants for the RV32I subset execute unit.
package rv32ex_pkg;

    // Architectural register file size and index width
    localparam int NUM_REGS  = 32;
    localparam int REG_IDX_W = $clog2(NUM_REGS);

    // Data memory defaults; the memory is split into four byte lanes
    localparam int DEF_MEM_BYTES = 4096;
    localparam int LANES         = 4;

    // Operation codes carried in req_type
    typedef enum logic [4:0] {
        OP_ADD  = 5'd0,
        OP_SUB  = 5'd1,
        OP_AND  = 5'd2,
        OP_OR   = 5'd3,
        OP_XOR  = 5'd4,
        OP_SLT  = 5'd5,
        OP_SLL  = 5'd6,
        OP_SRA  = 5'd7,
        OP_ADDI = 5'd8,
        OP_ANDI = 5'd9,
        OP_ORI  = 5'd10,
        OP_XORI = 5'd11,
        OP_SLTI = 5'd12,
        OP_LW   = 5'd13,
        OP_LB   = 5'd14,
        OP_SW   = 5'd15,
        OP_SB   = 5'd16,
        OP_LUI  = 5'd17
    } op_t;

    // One decoded instruction
    typedef struct packed {
        logic [4:0]         req_type;
        logic [4:0]         dest_reg;
        logic [4:0]         src1_reg;
        logic [4:0]         src2_reg;
        logic signed [11:0] short_imm;
        logic [19:0]        upper_imm;
    } exec_req_t;

    // One execution result
    typedef struct packed {
        logic               reg_written;
        logic [4:0]         written_reg;
        logic signed [31:0] written_value;
        logic               mem_written;
        logic [31:0]        mem_address;
    } exec_rsp_t;

endpackage

### design/rv32i_subset_execute_unit_top.sv
// Execute unit for an RV32I subset: register file, ALU, byte-lane data memory.
//
// Usage:
//   req channel (req_valid/req_ready/req) takes one decoded instruction per beat.
//   rsp channel (rsp_valid/rsp_ready/rsp) returns one result beat per instruction,
//   in order.
//   Pipeline: register file read at accept, execute and data memory access in the
//   next stage, write-back into the register file and the output register after it.
//   Throughput is one instruction per cycle while rsp_ready holds no result back,
//   set by the single write port of the register file and one access per byte
//   lane of the data memory. Results of the write-back stage are forwarded, also
//   on the edge they are written, so dependent instructions issue back to back.
//   Reset: register file reads as zero through per-entry valid bits. The data
//   memory is cleared by a sweep over its MEM_BYTES/4 rows (one row of four byte
//   lanes per cycle); req_ready stays low until the sweep is done.
//   Stall: when rsp_ready is low the result holds in the output register; earlier
//   stages keep filling until they are all occupied, then req_ready drops.
//   MEM_BYTES must be a power of two; addresses wrap modulo MEM_BYTES.
module rv32i_subset_execute_unit_top
    import rv32ex_pkg::*;
#(
    parameter int MEM_BYTES = DEF_MEM_BYTES
)(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  exec_req_t req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output exec_rsp_t rsp
);

    localparam int AW   = $clog2(MEM_BYTES);
    localparam int RW   = AW - 2;
    localparam int ROWS = MEM_BYTES / LANES;

    // ---------------- Pipeline control ----------------
    logic out_adv;
    logic s2_adv;
    logic s1_adv;
    logic s1_go;
    logic accept;
    logic rf_we;

    logic rsp_valid_reg;
    logic s1_v_reg;
    logic s2_v_reg;
    logic clr_active_reg;
    logic [RW-1:0] clr_cnt_reg;

    // ---------------- Register file ----------------
    logic [31:0]         rf_mem [NUM_REGS];
    logic [NUM_REGS-1:0] rf_vld_reg;
    logic [REG_IDX_W-1:0] b_idx;
    logic                 req_is_store;
    logic [31:0]          rd_a_reg;
    logic [31:0]          rd_b_reg;
    logic                 vld_a_reg;
    logic                 vld_b_reg;
    logic                 byp_a_reg;
    logic                 byp_b_reg;
    logic [31:0]          fwd_a_reg;
    logic [31:0]          fwd_b_reg;

    // ---------------- Execute stage ----------------
    exec_req_t            s1_req_reg;
    logic [REG_IDX_W-1:0] s1_bidx_reg;
    logic                 hit_a;
    logic                 hit_b;
    logic [31:0]          opa;
    logic [31:0]          opb;
    logic [31:0]          imm_ext;
    logic [31:0]          eff_addr;
    logic [31:0]          alu_val;
    logic                 alu_wr;
    logic                 ld_w;
    logic                 ld_b;
    logic                 st_w;
    logic                 st_b;
    logic                 mem_op;
    logic [1:0]           off;
    logic [RW-1:0]        row;

    // ---------------- Data memory ----------------
    logic [7:0]    dmem [LANES][ROWS];
    logic [RW-1:0] lane_row [LANES];
    logic [7:0]    lane_wdata [LANES];
    logic [LANES-1:0] lane_we;
    logic [7:0]    lane_rdata_reg [LANES];

    // ---------------- Write-back stage ----------------
    logic                 s2_wr_next;
    logic                 s2_wr_reg;
    logic [REG_IDX_W-1:0] s2_rd_reg;
    logic [31:0]          s2_val_reg;
    logic                 s2_ld_w_reg;
    logic                 s2_ld_b_reg;
    logic [1:0]           s2_off_reg;
    logic                 s2_mw_reg;
    logic [31:0]          s2_addr_reg;
    logic [31:0]          ld_word;
    logic [31:0]          ld_byte;
    logic [31:0]          wb_val;
    exec_rsp_t            rsp_next;
    exec_rsp_t            rsp_reg;

    // Stage advance chain: each stage moves when the next one has room
    always_comb
    begin
        out_adv   = !rsp_valid_reg || rsp_ready;
        s2_adv    = !s2_v_reg || out_adv;
        s1_adv    = !s1_v_reg || s2_adv;
        s1_go     = s1_v_reg && s2_adv;
        req_ready = !clr_active_reg && s1_adv;
        accept    = req_valid && req_ready;
        rf_we     = s2_v_reg && out_adv && s2_wr_reg;
    end

    // Second read port serves rs2, or the store data register for stores
    always_comb
    begin
        req_is_store = (req.req_type == OP_SW) || (req.req_type == OP_SB);
        b_idx        = req_is_store ? req.dest_reg : req.src2_reg;
    end

    // Control state, valid bits and bypass flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg  <= 1'b0;
            s1_v_reg       <= 1'b0;
            s2_v_reg       <= 1'b0;
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
            rf_vld_reg     <= '0;
            vld_a_reg      <= 1'b0;
            vld_b_reg      <= 1'b0;
            byp_a_reg      <= 1'b0;
            byp_b_reg      <= 1'b0;
        end
        else
        begin
            if (clr_active_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + RW'(1);
                if (clr_cnt_reg == RW'(ROWS - 1))
                begin
                    clr_active_reg <= 1'b0;
                end
            end
            if (out_adv)
            begin
                rsp_valid_reg <= s2_v_reg;
            end
            if (s2_adv)
            begin
                s2_v_reg <= s1_v_reg;
            end
            if (s1_adv)
            begin
                s1_v_reg <= accept;
            end
            if (rf_we)
            begin
                rf_vld_reg[s2_rd_reg] <= 1'b1;
            end
            if (accept)
            begin
                vld_a_reg <= rf_vld_reg[req.src1_reg];
                vld_b_reg <= rf_vld_reg[b_idx];
                // a write landing on the same edge as the read is caught here
                byp_a_reg <= rf_we && (s2_rd_reg == req.src1_reg);
                byp_b_reg <= rf_we && (s2_rd_reg == b_idx);
            end
        end
    end

    // Register file storage and registered read ports
    always_ff @(posedge clk)
    begin
        if (rf_we)
        begin
            rf_mem[s2_rd_reg] <= wb_val;
        end
        if (accept)
        begin
            rd_a_reg    <= rf_mem[req.src1_reg];
            rd_b_reg    <= rf_mem[b_idx];
            fwd_a_reg   <= wb_val;
            fwd_b_reg   <= wb_val;
            s1_req_reg  <= req;
            s1_bidx_reg <= b_idx;
        end
    end

    // Operand select: write-back stage first, then same-edge bypass, then file
    always_comb
    begin
        hit_a = s2_v_reg && s2_wr_reg && (s2_rd_reg == s1_req_reg.src1_reg);
        hit_b = s2_v_reg && s2_wr_reg && (s2_rd_reg == s1_bidx_reg);
        opa   = hit_a ? wb_val : (byp_a_reg ? fwd_a_reg : (vld_a_reg ? rd_a_reg : '0));
        opb   = hit_b ? wb_val : (byp_b_reg ? fwd_b_reg : (vld_b_reg ? rd_b_reg : '0));
    end

    // ALU and operation decode
    always_comb
    begin
        imm_ext  = {{20{s1_req_reg.short_imm[11]}}, s1_req_reg.short_imm};
        eff_addr = opa + imm_ext;
        alu_val  = '0;
        alu_wr   = 1'b0;
        ld_w     = 1'b0;
        ld_b     = 1'b0;
        st_w     = 1'b0;
        st_b     = 1'b0;
        mem_op   = 1'b0;
        unique case (s1_req_reg.req_type)
            OP_ADD:  begin alu_val = opa + opb;                      alu_wr = 1'b1; end
            OP_SUB:  begin alu_val = opa - opb;                      alu_wr = 1'b1; end
            OP_AND:  begin alu_val = opa & opb;                      alu_wr = 1'b1; end
            OP_OR:   begin alu_val = opa | opb;                      alu_wr = 1'b1; end
            OP_XOR:  begin alu_val = opa ^ opb;                      alu_wr = 1'b1; end
            OP_SLT:  begin alu_val = {31'b0, $signed(opa) < $signed(opb)}; alu_wr = 1'b1; end
            OP_SLL:  begin alu_val = opa << opb[4:0];                alu_wr = 1'b1; end
            OP_SRA:  begin alu_val = 32'($signed(opa) >>> opb[4:0]); alu_wr = 1'b1; end
            OP_ADDI: begin alu_val = eff_addr;                       alu_wr = 1'b1; end
            OP_ANDI: begin alu_val = opa & imm_ext;                  alu_wr = 1'b1; end
            OP_ORI:  begin alu_val = opa | imm_ext;                  alu_wr = 1'b1; end
            OP_XORI: begin alu_val = opa ^ imm_ext;                  alu_wr = 1'b1; end
            OP_SLTI: begin alu_val = {31'b0, $signed(opa) < $signed(imm_ext)}; alu_wr = 1'b1; end
            OP_LW:   begin ld_w = 1'b1; alu_wr = 1'b1; mem_op = 1'b1; end
            OP_LB:   begin ld_b = 1'b1; alu_wr = 1'b1; mem_op = 1'b1; end
            OP_SW:   begin st_w = 1'b1; mem_op = 1'b1; end
            OP_SB:   begin st_b = 1'b1; mem_op = 1'b1; end
            OP_LUI:  begin alu_val = {s1_req_reg.upper_imm, 12'b0}; alu_wr = 1'b1; end
            default: ;
        endcase
        s2_wr_next = alu_wr && (s1_req_reg.dest_reg != '0);
        off        = eff_addr[1:0];
        row        = eff_addr[AW-1:2];
    end

    // Byte lane steering: a word access spills into the next row for low lanes
    always_comb
    begin
        logic [1:0] lane_idx;
        logic [1:0] byte_sel;
        for (int l = 0; l < LANES; l++)
        begin
            lane_idx = 2'(l);
            byte_sel = lane_idx - off;
            if (clr_active_reg)
            begin
                lane_row[l]   = clr_cnt_reg;
                lane_we[l]    = 1'b1;
                lane_wdata[l] = '0;
            end
            else
            begin
                lane_row[l]   = row + RW'(lane_idx < off);
                lane_we[l]    = s1_go && (st_w || (st_b && (lane_idx == off)));
                lane_wdata[l] = st_w ? 8'(opb >> {byte_sel, 3'b000}) : opb[7:0];
            end
        end
    end

    // Data memory banks, one per byte lane
    always_ff @(posedge clk)
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if (lane_we[l])
            begin
                dmem[l][lane_row[l]] <= lane_wdata[l];
            end
            if (s1_go)
            begin
                lane_rdata_reg[l] <= dmem[l][lane_row[l]];
            end
        end
    end

    // Execute to write-back stage register
    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            s2_wr_reg   <= s2_wr_next;
            s2_rd_reg   <= s2_wr_next ? s1_req_reg.dest_reg : '0;
            s2_val_reg  <= alu_val;
            s2_ld_w_reg <= ld_w;
            s2_ld_b_reg <= ld_b;
            s2_off_reg  <= off;
            s2_mw_reg   <= st_w || st_b;
            s2_addr_reg <= mem_op ? eff_addr : '0;
        end
    end

    // Load alignment and write-back value
    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            ld_word[8*k +: 8] = lane_rdata_reg[s2_off_reg + 2'(k)];
        end
        ld_byte = {{24{lane_rdata_reg[s2_off_reg][7]}}, lane_rdata_reg[s2_off_reg]};
        wb_val  = s2_ld_w_reg ? ld_word : (s2_ld_b_reg ? ld_byte : s2_val_reg);

        rsp_next.reg_written   = s2_wr_reg;
        rsp_next.written_reg   = s2_rd_reg;
        rsp_next.written_value = s2_wr_reg ? wb_val : '0;
        rsp_next.mem_written   = s2_mw_reg;
        rsp_next.mem_address   = s2_addr_reg;
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (out_adv && s2_v_reg)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ---------------- Assertions ----------------
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> !req_ready)
        else $error("instruction accepted during memory clear");

    a_no_x0_write: assert property (@(posedge clk) disable iff (!rst_n)
        rf_we |-> (s2_rd_reg != '0))
        else $error("register file write to x0");

    a_quiet_when_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.reg_written) |-> (rsp.written_reg == '0 && rsp.written_value == '0))
        else $error("nonzero write fields without a register write");

    a_store_no_reg_write: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.mem_written) |-> !rsp.reg_written)
        else $error("store reported a register write");

    a_pipe_order: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_v_reg && !s2_v_reg) |-> s1_adv)
        else $error("execute stage stalled behind an empty write-back stage");

endmodule
